[rtl/core/hci_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hci_pkg
// Shared constants, types and helpers for the Hilbert curve index pipeline.
// ----------------------------------------------------------------------------
package hci_pkg;

  localparam int MAX_ORDER        = 16;
  localparam int COORD_W          = 16;
  localparam int ORDER_W          = 5;
  localparam int INDEX_W          = 32;
  localparam int LEVELS_PER_STAGE = 4;
  localparam int NUM_STAGES       = MAX_ORDER / LEVELS_PER_STAGE;

  // Item state carried between pipeline stages. Coordinates and the level
  // enable mask are shifted left one bit per level; the top bit is the
  // level being worked on.
  typedef struct packed {
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [MAX_ORDER-1:0] lvl_en;
    logic [1:0]           rot;
    logic                 flip;
    logic [INDEX_W-1:0]   index;
  } hci_carry_t;

  // Rotation advance per rotated quadrant: {3, 0, 0, 1}.
  function automatic logic [1:0] rot_step(input logic [1:0] q);
    logic [1:0] r;
    unique case (q)
      2'd0:    r = 2'd3;
      2'd1:    r = 2'd0;
      2'd2:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/hilbert_curve_index.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hilbert_curve_index
// Maps a 2D point (coord_x, coord_y) to its position along a Hilbert curve.
//
// Input channel: in_valid / in_ready with coord_x, coord_y. Output channel:
// out_valid / out_ready with curve_index. An item moves on a cycle where
// valid and ready are both high.
// Config: cfg_we writes cfg_data into curve_order (reset value 16); values
// above 16 act as 16. Write only while the pipeline is empty.
// Four register stages, four curve levels each. One item is accepted every
// cycle while in_ready is high; in_ready stays high as long as the receiver
// keeps out_ready high.
// The last stage is the output register. When the receiver stalls, each
// stage holds its item and bubbles collapse; in_ready drops only once every
// stage is full.
// Reset (rst, synchronous) empties the pipeline and sets curve_order to 16.
// ----------------------------------------------------------------------------
module hilbert_curve_index
  import hci_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [ORDER_W-1:0] cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [COORD_W-1:0] coord_x,
  input  wire logic [COORD_W-1:0] coord_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [INDEX_W-1:0]      curve_index
);

  logic [ORDER_W-1:0]   curve_order;
  logic [ORDER_W-1:0]   order_sat;
  logic [MAX_ORDER:0]   en_wide;
  hci_carry_t           head;

  logic       stg_valid [NUM_STAGES+1];
  logic       stg_ready [NUM_STAGES+1];
  hci_carry_t stg_data  [NUM_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_order <= ORDER_W'(MAX_ORDER);
    end else if (cfg_we) begin
      curve_order <= cfg_data;
    end
  end

  always_comb begin
    order_sat = (curve_order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : curve_order;
    en_wide   = ((MAX_ORDER+1)'(1) << order_sat) - (MAX_ORDER+1)'(1);
    head.x      = coord_x;
    head.y      = coord_y;
    head.lvl_en = en_wide[MAX_ORDER-1:0];
    head.rot    = 2'd0;
    head.flip   = 1'b0;
    head.index  = '0;
  end

  assign stg_valid[0] = in_valid;
  assign stg_data[0]  = head;
  assign in_ready     = stg_ready[0];

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    hci_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[s]),
      .in_ready  (stg_ready[s]),
      .in_data   (stg_data[s]),
      .out_valid (stg_valid[s+1]),
      .out_ready (stg_ready[s+1]),
      .out_data  (stg_data[s+1])
    );
  end

  assign stg_ready[NUM_STAGES] = out_ready;
  assign out_valid   = stg_valid[NUM_STAGES];
  assign curve_index = stg_data[NUM_STAGES].index;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_ready_pass: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

endmodule
`default_nettype wire

[rtl/core/hci_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hci_stage
// One pipeline stage: resolves LEVELS_PER_STAGE curve levels, top bit first.
// ----------------------------------------------------------------------------
module hci_stage
  import hci_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire hci_carry_t in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output hci_carry_t      out_data
);

  hci_carry_t data_next;

  always_comb begin
    hci_carry_t c;
    logic [1:0] q;
    logic       xb;
    logic       yb;
    logic [1:0] digit;
    c = in_data;
    for (int i = 0; i < LEVELS_PER_STAGE; i++) begin
      xb    = c.x[COORD_W-1];
      yb    = c.y[COORD_W-1];
      q     = {yb, xb ^ yb} + c.rot;
      digit = 2'd0;
      if (c.lvl_en[MAX_ORDER-1]) begin
        digit  = q ^ {2{c.flip}};
        c.rot  = c.rot + rot_step(q);
        c.flip = c.flip ^ ((q == 2'd0) || (q == 2'd3));
      end
      c.index  = {c.index[INDEX_W-3:0], digit};
      c.x      = {c.x[COORD_W-2:0], 1'b0};
      c.y      = {c.y[COORD_W-2:0], 1'b0};
      c.lvl_en = {c.lvl_en[MAX_ORDER-2:0], 1'b0};
    end
    data_next = c;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

[tb/tb_hilbert_curve_index.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hilbert_curve_index
// Self-checking bench for the Hilbert curve index pipeline. A queued driver
// offers points in random bursts, and a monitor stalls the result side on
// shifting patterns. Each accepted point is scored against a local model of
// the curve walk under the current order. The order register is rewritten
// between drained phases, covering zero, small orders, the full order and
// saturated values.
// ----------------------------------------------------------------------------
module tb_hilbert_curve_index;
  import hci_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int RESET_TICKS = 9;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 78;
  localparam logic [1:0] TURN [4] = '{2'd3, 2'd0, 2'd0, 2'd1};

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_we      = 1'b0;
  logic [ORDER_W-1:0] cfg_data    = '0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [COORD_W-1:0] coord_x     = '0;
  logic [COORD_W-1:0] coord_y     = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic [INDEX_W-1:0] curve_index;

  point_t             point_queue[$];
  logic [INDEX_W-1:0] pending_index[$];
  logic [ORDER_W-1:0] order_shadow = ORDER_W'(MAX_ORDER);
  int                 errors       = 0;
  int                 cycle_count  = 0;
  int                 results_seen = 0;

  hilbert_curve_index i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .curve_index (curve_index)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic [INDEX_W-1:0] hilbert_index(input logic [COORD_W-1:0] px,
                                                       input logic [COORD_W-1:0] py,
                                                       input logic [ORDER_W-1:0] ord);
    int         levels;
    int         lvl;
    logic [1:0] quad_of [1:MAX_ORDER];
    logic [1:0] rot;
    logic [1:0] q;
    logic [63:0] acc;
    logic [63:0] sub;
    levels = (ord > MAX_ORDER) ? MAX_ORDER : int'(ord);
    rot    = 2'd0;
    for (lvl = levels; lvl >= 1; lvl--) begin
      if (px[lvl-1] == 1'b0) begin
        q = py[lvl-1] ? 2'd3 : 2'd0;
      end else begin
        q = py[lvl-1] ? 2'd2 : 2'd1;
      end
      q            = q + rot;
      quad_of[lvl] = q;
      rot          = rot + TURN[q];
    end
    acc = '0;
    for (lvl = 1; lvl <= levels; lvl++) begin
      sub = 64'd1 << (2 * lvl - 2);
      q   = quad_of[lvl];
      if (q == 2'd1 || q == 2'd2) begin
        acc = {62'd0, q} * sub + acc;
      end else begin
        acc = {62'd0, q} * sub + (sub - acc - 64'd1);
      end
    end
    return acc[INDEX_W-1:0];
  endfunction

  function automatic point_t gen_point(input int ord);
    point_t             p;
    int                 sel;
    logic [31:0]        full;
    logic [COORD_W-1:0] lim;
    full = (32'd1 << ord) - 32'd1;
    lim  = full[COORD_W-1:0];
    sel  = $urandom_range(0, 9);
    p.x  = COORD_W'($urandom);
    p.y  = COORD_W'($urandom);
    if (sel < 5) begin
      p.x = p.x & lim;
      p.y = p.y & lim;
    end else if (sel == 5) begin
      p.x = lim;
      p.y = '0;
    end else if (sel == 6) begin
      p.x = '0;
      p.y = lim;
    end else if (sel == 7) begin
      p.x = lim;
      p.y = lim;
    end
    return p;
  endfunction

  task automatic push_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
    point_t p;
    p.x = px;
    p.y = py;
    point_queue = {point_queue, p};
  endtask

  task automatic drain();
    while (point_queue.size() != 0 || in_valid || pending_index.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic set_order(input int ord);
    drain();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= ORDER_W'(ord);
    @(posedge clk);
    cfg_we       <= 1'b0;
    order_shadow  = ORDER_W'(ord);
    @(negedge clk);
  endtask

  // driver
  int     gap_left   = 0;
  int     burst_left = 1;
  point_t next_pt;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_index = {pending_index, hilbert_index(coord_x, coord_y, order_shadow)};
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || point_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          next_pt   = point_queue.pop_front();
          in_valid <= 1'b1;
          coord_x  <= next_pt.x;
          coord_y  <= next_pt.y;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
    end
  end

  // monitor and result-side stalls
  int             hold_cnt  = 0;
  int             mode      = 0;
  int             mode_left = 0;
  logic [INDEX_W-1:0] want;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_index.size() == 0) begin
        $display("%0t ERROR curve_index: expected none, actual %h", $time, curve_index);
        errors++;
      end else begin
        want = pending_index.pop_front();
        if (want !== curve_index) begin
          $display("%0t ERROR curve_index: expected %h, actual %h", $time, want, curve_index);
          errors++;
        end
      end
      results_seen++;
      if (results_seen == 200 || results_seen == 800) hold_cnt = 80;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(5, 60);
      end else begin
        mode_left--;
      end
      case (mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_ready <= ~out_ready;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hilbert_curve_index verification failed");
      $finish;
    end
  end

  int orders [16] = '{16, 0, 1, 2, 3, 4, 5, 7, 8, 11, 12, 15, 16, 17, 24, 31};

  initial begin
    int ph;
    int k;
    repeat (RESET_TICKS) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // full order out of reset: corners, top bits, alternating patterns
    push_point(16'h0000, 16'h0000);
    push_point(16'hFFFF, 16'hFFFF);
    push_point(16'hFFFF, 16'h0000);
    push_point(16'h0000, 16'hFFFF);
    push_point(16'h8000, 16'h0000);
    push_point(16'h0000, 16'h8000);
    push_point(16'hAAAA, 16'h5555);
    push_point(16'h5555, 16'hAAAA);
    push_point(16'h0001, 16'h0001);
    push_point(16'h7FFF, 16'h8000);

    // order zero gives index zero whatever the point
    set_order(0);
    push_point(16'h0000, 16'h0000);
    push_point(16'hFFFF, 16'hFFFF);

    // order one, high bits must be masked off
    set_order(1);
    push_point(16'hFFFE, 16'h0000);
    push_point(16'h1234, 16'hFFFF);
    push_point(16'hFFFF, 16'hABCE);
    push_point(16'h8001, 16'h7FFF);

    // beyond the maximum order saturates
    set_order(31);
    push_point(16'hFFFF, 16'h0000);
    push_point(16'h1234, 16'h5678);
    push_point(16'h8000, 16'h8000);

    set_order(2);
    push_point(16'h0003, 16'h0000);
    push_point(16'h0001, 16'h0002);
    push_point(16'hFFF2, 16'hFFF1);
    push_point(16'h0003, 16'h0003);

    for (ph = 0; ph < 16; ph++) begin
      set_order(orders[ph]);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        point_queue = {point_queue, gen_point(orders[ph])};
      end
    end

    drain();
    if (errors == 0 && pending_index.size() == 0) begin
      $display("hilbert_curve_index verification clean");
    end else begin
      $display("hilbert_curve_index verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/hci_pkg.sv
rtl/core/hci_stage.sv
rtl/core/hilbert_curve_index.sv
tb/tb_hilbert_curve_index.sv
